FILE: hw/rtl/tms_pkg.sv
// Shared types, codes and helpers for the tween motion sequencer.
// Used by tms_unit, tms_ctrl and tween_motion_sequencer; depends on nothing else.
package tms_pkg;

  // Item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_PLAY    = 3'd1;
  localparam logic [2:0] KIND_PAUSE   = 3'd2;
  localparam logic [2:0] KIND_RESUME  = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;
  localparam logic [2:0] KIND_RESTART = 3'd5;
  localparam logic [2:0] KIND_ROUTE   = 3'd6;

  // Playback modes as reported on mode_now
  localparam logic [2:0] MODE_IDLE        = 3'd0;
  localparam logic [2:0] MODE_ACTIVE      = 3'd1;
  localparam logic [2:0] MODE_LOOP_GAP    = 3'd2;
  localparam logic [2:0] MODE_FINISH_WAIT = 3'd3;
  localparam logic [2:0] MODE_PAUSED      = 3'd4;
  localparam logic [2:0] MODE_FINISHED    = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_DURATION     = 3'd0;
  localparam logic [2:0] CFG_LOOP_COUNT   = 3'd1;
  localparam logic [2:0] CFG_LOOP_GAP     = 3'd2;
  localparam logic [2:0] CFG_FINISH_WAIT  = 3'd3;
  localparam logic [2:0] CFG_START_POINT  = 3'd4;
  localparam logic [2:0] CFG_END_POINT    = 3'd5;
  localparam logic [2:0] CFG_ROUTE_LENGTH = 3'd6;

  // Progress of 1.0 in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic {
    OP_DIV_STEP,
    OP_MUL
  } unit_op_e;

  typedef struct packed {
    logic [15:0] duration;
    logic [7:0]  loop_count;
    logic [15:0] loop_gap;
    logic [15:0] finish_wait;
  } tween_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       started;
    logic       looped;
    logic       completed;
    logic       pos_needed;
  } tween_evt_t;

  typedef struct packed {
    unit_op_e           op;
    logic [15:0]        rem;
    logic [15:0]        divisor;
    logic signed [17:0] mul_a;
    logic [16:0]        mul_b;
  } unit_req_t;

  typedef struct packed {
    logic [15:0]        rem;
    logic               qbit;
    logic signed [35:0] prod;
  } unit_rsp_t;

  // A zero duration runs as one tick
  function automatic logic [15:0] eff_duration(input logic [15:0] dur);
    eff_duration = (dur == 16'd0) ? 16'd1 : dur;
  endfunction

endpackage

FILE: hw/rtl/tms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/tms_unit.sv
// Shared arithmetic unit: one restoring-division step or one 18x18 multiply.
// Depends on tms_pkg for the request and response structs.
module tms_unit (
  input  tms_pkg::unit_req_t req_i,
  output tms_pkg::unit_rsp_t rsp_o
);
  import tms_pkg::*;

  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;

  assign shifted = {req_i.rem, 1'b0};
  assign diff    = shifted - {1'b0, req_i.divisor};
  assign ge      = shifted >= {1'b0, req_i.divisor};

  always_comb begin
    rsp_o = '0;
    unique case (req_i.op)
      OP_DIV_STEP: begin
        rsp_o.qbit = ge;
        rsp_o.rem  = ge ? diff[15:0] : shifted[15:0];
      end
      OP_MUL: begin
        rsp_o.prod = $signed(req_i.mul_a) * $signed({1'b0, req_i.mul_b});
      end
    endcase
  end

endmodule

FILE: hw/rtl/tms_ctrl.sv
// Playback control: mode, held mode, elapsed count, loops and delay counters.
// Depends on tms_pkg for codes, config and event structs.
module tms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          kind_i,
  input  tms_pkg::tween_cfg_t cfg_i,
  output tms_pkg::tween_evt_t evt_o,
  output logic [15:0]         elapsed_o
);
  import tms_pkg::*;

  logic [2:0]  mode_q, mode_d;
  logic [2:0]  held_q, held_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  loops_q, loops_d;
  logic [15:0] delay_q, delay_d;
  logic        started, looped, completed;
  logic [15:0] dur;
  logic [15:0] elapsed_inc;
  logic        idle_or_done;

  assign dur          = eff_duration(cfg_i.duration);
  assign elapsed_inc  = elapsed_q + {15'd0, elapsed_q != 16'hFFFF};
  assign idle_or_done = (mode_q == MODE_IDLE) || (mode_q == MODE_FINISHED);

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    elapsed_d = elapsed_q;
    loops_d   = loops_q;
    delay_d   = delay_q;
    started   = 1'b0;
    looped    = 1'b0;
    completed = 1'b0;
    unique case (kind_i) inside
      KIND_TICK: begin
        unique case (mode_q) inside
          MODE_ACTIVE: begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= dur) begin
              if (loops_q != 8'd0) begin
                loops_d   = loops_q - 8'd1;
                elapsed_d = 16'd0;
                looped    = 1'b1;
                if (cfg_i.loop_gap != 16'd0) begin
                  delay_d = cfg_i.loop_gap;
                  mode_d  = MODE_LOOP_GAP;
                end
              end else if (cfg_i.finish_wait != 16'd0) begin
                delay_d = cfg_i.finish_wait;
                mode_d  = MODE_FINISH_WAIT;
              end else begin
                completed = 1'b1;
                mode_d    = MODE_FINISHED;
              end
            end
          end
          MODE_LOOP_GAP, MODE_FINISH_WAIT: begin
            if (delay_q <= 16'd1) begin
              delay_d = 16'd0;
              if (mode_q == MODE_LOOP_GAP) begin
                mode_d = MODE_ACTIVE;
              end else begin
                completed = 1'b1;
                mode_d    = MODE_FINISHED;
              end
            end else begin
              delay_d = delay_q - 16'd1;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_PLAY, KIND_RESUME: begin
        if (mode_q == MODE_PAUSED) begin
          mode_d = held_q;
        end else if (idle_or_done) begin
          elapsed_d = 16'd0;
          loops_d   = cfg_i.loop_count;
          mode_d    = MODE_ACTIVE;
          started   = 1'b1;
        end
      end
      KIND_PAUSE: begin
        if (mode_q inside {MODE_ACTIVE, MODE_LOOP_GAP, MODE_FINISH_WAIT}) begin
          held_d = mode_q;
          mode_d = MODE_PAUSED;
        end
      end
      KIND_STOP: begin
        mode_d = MODE_FINISHED;
      end
      KIND_RESTART: begin
        elapsed_d = 16'd0;
        loops_d   = cfg_i.loop_count;
        mode_d    = MODE_ACTIVE;
        started   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      held_q    <= MODE_IDLE;
      elapsed_q <= 16'd0;
      loops_q   <= 8'd0;
      delay_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
      loops_q   <= loops_d;
      delay_q   <= delay_d;
    end
  end

  assign evt_o.mode       = mode_d;
  assign evt_o.started    = started;
  assign evt_o.looped     = looped;
  assign evt_o.completed  = completed;
  assign evt_o.pos_needed = (kind_i == KIND_TICK) && (mode_d == MODE_ACTIVE);
  assign elapsed_o        = elapsed_d;

endmodule

FILE: hw/rtl/tween_motion_sequencer.sv
// Tween motion sequencer: linear tween along a straight line or a route table.
// A tick that leaves the tween active runs the 16-step progress division, then the
// blend multiplies (after the route table reads on a route); other words go straight out.
// One word at a time: the next is taken only as the result leaves. Async active-low
// reset clears mode, counters, state and configuration registers; the route RAM keeps
// whatever was written.
module tween_motion_sequencer #(
  parameter int ROUTE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [5:0]         route_index_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               position_valid_o,
  output logic signed [23:0] x_pos_o,
  output logic signed [23:0] y_pos_o,
  output logic [2:0]         mode_now_o,
  output logic               started_o,
  output logic               looped_o,
  output logic               completed_o
);
  import tms_pkg::*;

  localparam int          AW      = $clog2(ROUTE_DEPTH);
  localparam logic [31:0] DEPTH_W = ROUTE_DEPTH;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_PROG  = 4'd2;
  localparam logic [3:0] S_RADDR = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_RDB   = 4'd5;
  localparam logic [3:0] S_MULX  = 4'd6;
  localparam logic [3:0] S_MULY  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // Configuration registers
  logic [15:0] duration_q;
  logic [7:0]  loop_count_q;
  logic [15:0] loop_gap_q;
  logic [15:0] finish_wait_q;
  logic [31:0] start_point_q;
  logic [31:0] end_point_q;
  logic [6:0]  route_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q     <= 16'd1;
      loop_count_q   <= 8'd0;
      loop_gap_q     <= 16'd0;
      finish_wait_q  <= 16'd0;
      start_point_q  <= 32'd0;
      end_point_q    <= 32'd0;
      route_length_q <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DURATION:     duration_q     <= cfg_data_i[15:0];
        CFG_LOOP_COUNT:   loop_count_q   <= cfg_data_i[7:0];
        CFG_LOOP_GAP:     loop_gap_q     <= cfg_data_i[15:0];
        CFG_FINISH_WAIT:  finish_wait_q  <= cfg_data_i[15:0];
        CFG_START_POINT:  start_point_q  <= cfg_data_i;
        CFG_END_POINT:    end_point_q    <= cfg_data_i;
        CFG_ROUTE_LENGTH: route_length_q <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  tween_cfg_t ctrl_cfg;
  assign ctrl_cfg.duration    = duration_q;
  assign ctrl_cfg.loop_count  = loop_count_q;
  assign ctrl_cfg.loop_gap    = loop_gap_q;
  assign ctrl_cfg.finish_wait = finish_wait_q;

  // Handshake: take a word only when the sequencer is free and the
  // output register is empty or draining this cycle.
  logic [3:0] state_q, state_d;
  logic       out_valid_q;
  logic       in_acc;
  logic       out_acc;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Playback control
  tween_evt_t  evt;
  logic [15:0] elapsed_new;

  tms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .kind_i    (kind_i),
    .cfg_i     (ctrl_cfg),
    .evt_o     (evt),
    .elapsed_o (elapsed_new)
  );

  // Route table
  logic [AW+6:0] wr_ext;
  logic [AW+6:0] rd_ext;
  logic [6:0]    rd_sel;
  logic          ram_we;
  logic          ram_re;
  logic [31:0]   ram_rdata;

  assign wr_ext = {{(AW + 1){1'b0}}, route_index_i};
  assign rd_ext = {{AW{1'b0}}, rd_sel};
  assign ram_we = in_acc && (kind_i == KIND_ROUTE) && ({26'd0, route_index_i} < DEPTH_W);

  tms_ram #(
    .WIDTH (32),
    .DEPTH (ROUTE_DEPTH)
  ) u_route_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (wr_ext[AW-1:0]),
    .wr_data_i ({point_x_i, point_y_i}),
    .rd_en_i   (ram_re),
    .rd_addr_i (rd_ext[AW-1:0]),
    .rd_data_o (ram_rdata)
  );

  // Shared arithmetic unit
  unit_req_t ureq;
  unit_rsp_t ursp;

  tms_unit u_unit (
    .req_i (ureq),
    .rsp_o (ursp)
  );

  // Datapath registers
  logic [3:0]         cnt_q, cnt_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        quo_q, quo_d;
  logic               clamp_q, clamp_d;
  logic [16:0]        f_q, f_d;
  logic [31:0]        a_q, a_d;
  logic [31:0]        b_q, b_d;
  logic signed [35:0] prod_q, prod_d;
  logic signed [23:0] x_q, x_d;
  logic [6:0]         next_q, next_d;

  // Output register
  logic               out_valid_d;
  logic               out_pos_q, out_pos_d;
  logic signed [23:0] out_x_q, out_x_d;
  logic signed [23:0] out_y_q, out_y_d;
  logic [2:0]         out_mode_q, out_mode_d;
  logic               out_start_q, out_start_d;
  logic               out_loop_q, out_loop_d;
  logic               out_done_q, out_done_d;

  // Route points in use, capped at the table depth
  logic [6:0]  n_pts;
  logic [16:0] prog;
  logic [6:0]  node;
  logic [15:0] frac;
  logic [6:0]  node_next;
  logic        single;
  logic [6:0]  node_last;
  logic [16:0] dx;
  logic [16:0] dy;
  logic [15:0] dur;

  assign n_pts     = ({25'd0, route_length_q} < DEPTH_W) ? route_length_q : DEPTH_W[6:0];
  assign prog      = clamp_q ? ONE_Q16 : {1'b0, quo_q};
  assign node      = prod_q[22:16];
  assign frac      = prod_q[15:0];
  assign node_next = node + {6'd0, frac != 16'd0};
  assign single    = node_next >= n_pts;
  assign node_last = (node < n_pts) ? node : (n_pts - 7'd1);
  assign dx        = {b_q[31], b_q[31:16]} - {a_q[31], a_q[31:16]};
  assign dy        = {b_q[15], b_q[15:0]} - {a_q[15], a_q[15:0]};
  assign dur       = eff_duration(duration_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    clamp_d     = clamp_q;
    f_d         = f_q;
    a_d         = a_q;
    b_d         = b_q;
    prod_d      = prod_q;
    x_d         = x_q;
    next_d      = next_q;
    out_valid_d = out_valid_q && !out_acc;
    out_pos_d   = out_pos_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_mode_d  = out_mode_q;
    out_start_d = out_start_q;
    out_loop_d  = out_loop_q;
    out_done_d  = out_done_q;
    ram_re      = 1'b0;
    rd_sel      = next_q;
    ureq        = '0;
    ureq.op     = OP_DIV_STEP;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // Flags and mode are captured now; they go out with the position when one is needed.
          out_pos_d   = evt.pos_needed;
          out_mode_d  = evt.mode;
          out_start_d = evt.started;
          out_loop_d  = evt.looped;
          out_done_d  = evt.completed;
          out_x_d     = '0;
          out_y_d     = '0;
          if (evt.pos_needed) begin
            rem_d   = elapsed_new;
            quo_d   = '0;
            cnt_d   = '0;
            clamp_d = elapsed_new >= dur;
            state_d = S_DIV;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_DIV: begin
        // One quotient bit a cycle of elapsed * 65536 / duration
        ureq.op      = OP_DIV_STEP;
        ureq.rem     = rem_q;
        ureq.divisor = dur;
        rem_d        = ursp.rem;
        quo_d        = {quo_q[14:0], ursp.qbit};
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_PROG;
        end
      end
      S_PROG: begin
        if (n_pts == 7'd0) begin
          f_d     = prog;
          a_d     = start_point_q;
          b_d     = end_point_q;
          state_d = S_MULX;
        end else begin
          ureq.op    = OP_MUL;
          ureq.mul_a = {11'd0, n_pts};
          ureq.mul_b = prog;
          prod_d     = ursp.prod;
          state_d    = S_RADDR;
        end
      end
      S_RADDR: begin
        // At or past the last point: hold that point, no blend.
        ram_re  = 1'b1;
        rd_sel  = single ? node_last : node;
        next_d  = single ? node_last : node_next;
        f_d     = single ? 17'd0 : {1'b0, frac};
        state_d = S_RDA;
      end
      S_RDA: begin
        ram_re  = 1'b1;
        rd_sel  = next_q;
        a_d     = ram_rdata;
        state_d = S_RDB;
      end
      S_RDB: begin
        b_d     = ram_rdata;
        state_d = S_MULX;
      end
      S_MULX: begin
        ureq.op    = OP_MUL;
        ureq.mul_a = {dx[16], dx};
        ureq.mul_b = f_q;
        prod_d     = ursp.prod;
        state_d    = S_MULY;
      end
      S_MULY: begin
        // Arithmetic shift floors the blend at the Q16.8 grid.
        x_d        = {a_q[31:16], 8'h00} + prod_q[31:8];
        ureq.op    = OP_MUL;
        ureq.mul_a = {dy[16], dy};
        ureq.mul_b = f_q;
        prod_d     = ursp.prod;
        state_d    = S_FIN;
      end
      S_FIN: begin
        out_x_d     = x_q;
        out_y_d     = {a_q[15:0], 8'h00} + prod_q[31:8];
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    clamp_q     <= clamp_d;
    f_q         <= f_d;
    a_q         <= a_d;
    b_q         <= b_d;
    prod_q      <= prod_d;
    x_q         <= x_d;
    next_q      <= next_d;
    out_pos_q   <= out_pos_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_mode_q  <= out_mode_d;
    out_start_q <= out_start_d;
    out_loop_q  <= out_loop_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o      = out_valid_q;
  assign position_valid_o = out_pos_q;
  assign x_pos_o          = out_x_q;
  assign y_pos_o          = out_y_q;
  assign mode_now_o       = out_mode_q;
  assign started_o        = out_start_q;
  assign looped_o         = out_loop_q;
  assign completed_o      = out_done_q;

endmodule
